@@ rtl/dmpq_pkg.sv @@
// ----------------------------------------------------------------------------
// dmpq_pkg
// Shared constants, types and table functions for the diatonic mode pitch
// quantizer: fixed-point scale, mode tables and semitone rounding.
// ----------------------------------------------------------------------------
package dmpq_pkg;

  // default control voltage width
  localparam int CV_WIDTH_DEF = 16;

  // one volt is 3 * 1024 units; the low part is split off by bit position
  localparam int LOW_W  = 10;
  localparam int FRAC_W = LOW_W + 2;   // remainder within one volt, 0..3071
  localparam int SEMI_W = 8;           // one semitone is 256 units
  localparam int NOTE_W = 4;           // pitch class 0..11
  localparam int DIST_W = FRAC_W;      // distance between remainder and a degree
  localparam int DEGREES = 7;

  localparam logic [NOTE_W-1:0] NOTES_PER_OCT = 4'd12;
  localparam logic [FRAC_W-1:0] HALF_SEMI     = 12'd128;

  // church modes, in output code order
  typedef enum logic [2:0] {
    MODE_IONIAN     = 3'd0,
    MODE_DORIAN     = 3'd1,
    MODE_PHRYGIAN   = 3'd2,
    MODE_LYDIAN     = 3'd3,
    MODE_MIXOLYDIAN = 3'd4,
    MODE_AEOLIAN    = 3'd5,
    MODE_LOCRIAN    = 3'd6
  } mode_t;

  // per-stage advance strobes for the remainder pipeline
  typedef struct packed {
    logic s1;
    logic s2;
  } stage_en_t;

  // semitone offsets of the seven degrees of each mode
  localparam logic [NOTE_W-1:0] MODE_TABLE [DEGREES][DEGREES] = '{
    '{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd11},
    '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd9, 4'd10},
    '{4'd0, 4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10},
    '{4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11},
    '{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd10},
    '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10},
    '{4'd0, 4'd1, 4'd3, 4'd5, 4'd6, 4'd8, 4'd10}
  };

  // round a remainder within one volt to the nearest semitone, mod 12
  function automatic logic [NOTE_W-1:0] semitone_step(logic [FRAC_W-1:0] frac);
    logic [FRAC_W-1:0] sum;
    logic [NOTE_W-1:0] step;
    sum  = frac + HALF_SEMI;
    step = sum[FRAC_W-1:SEMI_W];
    if (step == NOTES_PER_OCT) begin
      step = '0;
    end
    return step;
  endfunction

  // twelve-step index to mode
  function automatic mode_t step_to_mode(logic [NOTE_W-1:0] step);
    mode_t m;
    unique case (step)
      4'd0, 4'd1:  m = MODE_IONIAN;
      4'd2, 4'd3:  m = MODE_DORIAN;
      4'd4:        m = MODE_PHRYGIAN;
      4'd5, 4'd6:  m = MODE_LYDIAN;
      4'd7, 4'd8:  m = MODE_MIXOLYDIAN;
      4'd9, 4'd10: m = MODE_AEOLIAN;
      default:     m = MODE_LOCRIAN;
    endcase
    return m;
  endfunction

  // degree of a mode, rotated by the root, mod 12
  function automatic logic [NOTE_W-1:0] rotated_degree(mode_t m, logic [2:0] idx,
                                                       logic [NOTE_W-1:0] root);
    logic [NOTE_W-1:0] base;
    logic [NOTE_W:0]   sum;
    base = '0;
    if (m <= MODE_LOCRIAN && idx < 3'(DEGREES)) begin
      base = MODE_TABLE[m][idx];
    end
    sum = {1'b0, base} + {1'b0, root};
    if (sum >= {1'b0, NOTES_PER_OCT}) begin
      sum = sum - {1'b0, NOTES_PER_OCT};
    end
    return sum[NOTE_W-1:0];
  endfunction

endpackage

@@ rtl/dmpq_volt_frac.sv @@
// ----------------------------------------------------------------------------
// dmpq_volt_frac
// Two-stage floor remainder of a signed control voltage within one volt
// (3072 units). The volt count is taken mod 3 by a reciprocal multiply.
// ----------------------------------------------------------------------------
module dmpq_volt_frac #(
  parameter int CvWidth = dmpq_pkg::CV_WIDTH_DEF
) (
  input  logic                         clk,
  input  dmpq_pkg::stage_en_t          en,
  input  logic [CvWidth-1:0]           cv,
  output logic [dmpq_pkg::FRAC_W-1:0]  frac
);

  localparam int LowW       = dmpq_pkg::LOW_W;
  localparam int VoltW      = CvWidth - LowW;          // signed count of 1024-unit steps
  localparam int UnsW       = VoltW + 2;               // offset to unsigned
  localparam int RecipShift = 2 * UnsW;
  localparam int ProdW      = UnsW + RecipShift - 1;
  localparam longint unsigned RecipFull = ((64'd1 << RecipShift) + 64'd2) / 64'd3;
  localparam logic [RecipShift-2:0] RecipMul = RecipFull[RecipShift-2:0];
  // multiple of three, so the offset leaves the remainder mod 3 unchanged
  localparam logic [UnsW-1:0] OffsetK = UnsW'(3 << (VoltW - 1));

  logic [VoltW-1:0]  volt;
  logic [UnsW-1:0]   unsig;
  logic [ProdW-1:0]  prod_nxt;
  logic [ProdW-1:0]  prod_r;
  logic [UnsW-1:0]   unsig_r;
  logic [LowW-1:0]   low_r;
  logic [UnsW-2:0]   quot;
  logic [UnsW-1:0]   rem_full;
  logic [dmpq_pkg::FRAC_W-1:0] frac_nxt;
  logic [dmpq_pkg::FRAC_W-1:0] frac_r;

  // stage 1: offset the coarse count and multiply by the reciprocal of three
  assign volt     = cv[CvWidth-1:LowW];
  assign unsig    = {{2{volt[VoltW-1]}}, volt} + OffsetK;
  assign prod_nxt = ProdW'(unsig) * ProdW'(RecipMul);

  always_ff @(posedge clk) begin
    if (en.s1) begin
      prod_r  <= prod_nxt;
      unsig_r <= unsig;
      low_r   <= cv[LowW-1:0];
    end
  end

  // stage 2: remainder mod 3 joins the low bits
  assign quot     = prod_r[ProdW-1:RecipShift];
  assign rem_full = unsig_r - ({quot, 1'b0} + {1'b0, quot});
  assign frac_nxt = {rem_full[1:0], low_r};

  always_ff @(posedge clk) begin
    if (en.s2) begin
      frac_r <= frac_nxt;
    end
  end

  assign frac = frac_r;

endmodule

@@ rtl/diatonic_mode_pitch_quantizer.sv @@
// ----------------------------------------------------------------------------
// diatonic_mode_pitch_quantizer
// Snaps a 1 V/octave pitch to the nearest degree of a church mode on a root
// chosen by control voltage; 3072 units per volt, 256 per semitone.
// ----------------------------------------------------------------------------
// path: stages 1-2 (volt remainders), stage 3, stage 4, then the output register
// throughput: one transaction per cycle while out_stall is low; stages advance
//   independently, so bubbles collapse and in_stall rises only when all five stages are full
// stage depth is set by the reciprocal multiply that splits off the volt
// reset: synchronous active-low rst_n clears every stage valid bit
module diatonic_mode_pitch_quantizer #(
  parameter int CvWidth = dmpq_pkg::CV_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [CvWidth-1:0]           in_pitch_cv,
  input  logic signed [CvWidth-1:0]           in_root_cv,
  input  logic signed [CvWidth-1:0]           in_mode_cv,
  input  logic [3:0]                          in_voice,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [CvWidth:0]             out_quantized_cv,
  output logic [dmpq_pkg::NOTE_W-1:0]         out_root_note,
  output logic [2:0]                          out_mode_index,
  output logic [3:0]                          out_voice_out
);

  localparam int FracW  = dmpq_pkg::FRAC_W;
  localparam int NoteW  = dmpq_pkg::NOTE_W;
  localparam int DistW  = dmpq_pkg::DIST_W;
  localparam int Deg    = dmpq_pkg::DEGREES;
  localparam int SemiW  = dmpq_pkg::SEMI_W;
  localparam int OutW   = CvWidth + 1;

  // stage valid bits and advance strobes
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic adv1, adv2, adv3, adv4, adv5;
  dmpq_pkg::stage_en_t fr_en;

  // stage payloads
  logic [CvWidth-1:0]  pitch_s1_r, pitch_s2_r;
  logic [3:0]          voice_s1_r, voice_s2_r, voice_s3_r, voice_s4_r, voice_out_r;
  logic [FracW-1:0]    pitch_frac, root_frac, mode_frac;
  logic [OutW-1:0]     base_nxt, base_s3_r, base_s4_r;
  logic [FracW-1:0]    frac_s3_r;
  logic [NoteW-1:0]    root_nxt, root_s3_r, root_s4_r, root_out_r;
  dmpq_pkg::mode_t     mode_nxt, mode_s3_r, mode_s4_r, mode_out_r;
  logic [NoteW-1:0]    deg_nxt [Deg];
  logic [DistW-1:0]    dist_nxt [Deg];
  logic [NoteW-1:0]    deg_s4_r [Deg];
  logic [DistW-1:0]    dist_s4_r [Deg];
  logic [NoteW-1:0]    best_deg;
  logic [OutW-1:0]     quant_nxt, quant_out_r;

  // per-stage flow control: a stage moves when empty or when the next moves
  assign adv5     = !out_valid_r || !out_stall;
  assign adv4     = !v4_r || adv5;
  assign adv3     = !v3_r || adv4;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_stall = !adv1;
  assign fr_en    = '{s1: adv1, s2: adv2};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv1) v1_r        <= in_valid;
      if (adv2) v2_r        <= v1_r;
      if (adv3) v3_r        <= v2_r;
      if (adv4) v4_r        <= v3_r;
      if (adv5) out_valid_r <= v4_r;
    end
  end

  // stages 1-2: remainders within one volt
  dmpq_volt_frac #(.CvWidth(CvWidth)) u_pitch_frac (
    .clk(clk), .en(fr_en), .cv(in_pitch_cv), .frac(pitch_frac)
  );
  dmpq_volt_frac #(.CvWidth(CvWidth)) u_root_frac (
    .clk(clk), .en(fr_en), .cv(in_root_cv), .frac(root_frac)
  );
  dmpq_volt_frac #(.CvWidth(CvWidth)) u_mode_frac (
    .clk(clk), .en(fr_en), .cv(in_mode_cv), .frac(mode_frac)
  );

  always_ff @(posedge clk) begin
    if (adv1) begin
      pitch_s1_r <= in_pitch_cv;
      voice_s1_r <= in_voice;
    end
    if (adv2) begin
      pitch_s2_r <= pitch_s1_r;
      voice_s2_r <= voice_s1_r;
    end
  end

  // stage 3: root, mode and octave base (pitch minus its remainder)
  assign root_nxt = dmpq_pkg::semitone_step(root_frac);
  assign mode_nxt = dmpq_pkg::step_to_mode(dmpq_pkg::semitone_step(mode_frac));
  assign base_nxt = {pitch_s2_r[CvWidth-1], pitch_s2_r}
                  - {{(OutW-FracW){1'b0}}, pitch_frac};

  always_ff @(posedge clk) begin
    if (adv3) begin
      base_s3_r  <= base_nxt;
      frac_s3_r  <= pitch_frac;
      root_s3_r  <= root_nxt;
      mode_s3_r  <= mode_nxt;
      voice_s3_r <= voice_s2_r;
    end
  end

  // stage 4: rotated degrees and their distances from the remainder
  always_comb begin
    logic [FracW:0] diff;
    for (int i = 0; i < Deg; i++) begin
      deg_nxt[i]  = dmpq_pkg::rotated_degree(mode_s3_r, 3'(i), root_s3_r);
      diff        = {1'b0, frac_s3_r} - {1'b0, deg_nxt[i], {SemiW{1'b0}}};
      if (diff[FracW]) begin
        diff = -diff;
      end
      dist_nxt[i] = diff[DistW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      deg_s4_r   <= deg_nxt;
      dist_s4_r  <= dist_nxt;
      base_s4_r  <= base_s3_r;
      root_s4_r  <= root_s3_r;
      mode_s4_r  <= mode_s3_r;
      voice_s4_r <= voice_s3_r;
    end
  end

  // stage 5: pairwise tree, lower degree wins ties, then add to the base
  always_comb begin
    logic [DistW-1:0] d01, d23, d45, d03, d46, dfin;
    logic [NoteW-1:0] g01, g23, g45, g03, g46;
    g01 = (dist_s4_r[0] <= dist_s4_r[1]) ? deg_s4_r[0] : deg_s4_r[1];
    d01 = (dist_s4_r[0] <= dist_s4_r[1]) ? dist_s4_r[0] : dist_s4_r[1];
    g23 = (dist_s4_r[2] <= dist_s4_r[3]) ? deg_s4_r[2] : deg_s4_r[3];
    d23 = (dist_s4_r[2] <= dist_s4_r[3]) ? dist_s4_r[2] : dist_s4_r[3];
    g45 = (dist_s4_r[4] <= dist_s4_r[5]) ? deg_s4_r[4] : deg_s4_r[5];
    d45 = (dist_s4_r[4] <= dist_s4_r[5]) ? dist_s4_r[4] : dist_s4_r[5];
    g03 = (d01 <= d23) ? g01 : g23;
    d03 = (d01 <= d23) ? d01 : d23;
    g46 = (d45 <= dist_s4_r[6]) ? g45 : deg_s4_r[6];
    d46 = (d45 <= dist_s4_r[6]) ? d45 : dist_s4_r[6];
    dfin     = (d03 <= d46) ? d03 : d46;
    best_deg = (d03 <= d46) ? g03 : g46;
    quant_nxt = base_s4_r + {{(OutW-NoteW-SemiW){1'b0}}, best_deg, {SemiW{1'b0}}};
    if (dfin == '0) begin
      quant_nxt = base_s4_r + {{(OutW-NoteW-SemiW){1'b0}}, best_deg, {SemiW{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (adv5) begin
      quant_out_r <= quant_nxt;
      root_out_r  <= root_s4_r;
      mode_out_r  <= mode_s4_r;
      voice_out_r <= voice_s4_r;
    end
  end

  // result ports
  assign out_valid        = out_valid_r;
  assign out_quantized_cv = quant_out_r;
  assign out_root_note    = root_out_r;
  assign out_mode_index   = mode_out_r;
  assign out_voice_out    = voice_out_r;

`ifndef SYNTHESIS
  // results land on a semitone grid: the base is a whole number of volts
  a_semitone_grid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_quantized_cv[SemiW-1:0] == '0)
    else $error("quantized result off the semitone grid");

  // input stalls only when every stage holds a transaction
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v1_r && v2_r && v3_r && v4_r && out_valid_r))
    else $error("input stalled with a bubble in the pipeline");

  // a blocked stage 4 keeps its transaction
  a_hold_s4: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && !adv4) |=> (v4_r && $stable(base_s4_r)))
    else $error("stage 4 transaction lost while blocked");

  // result fields stay in range
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_root_note < 4'd12 && out_mode_index < 3'd7))
    else $error("root or mode index out of range");
`endif

endmodule
